@@ src/u8dec_pkg.sv @@
// ============================================================================
// u8dec_pkg: shared types and constants for the UTF-8 byte stream decoder
// Byte class constants, status codes and the result record.
// ============================================================================
package u8dec_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 16;
    localparam int LEN_W   = 2;
    localparam int STAT_W  = 2;
    localparam int PART_W  = 10;

    // Padded widths of the stream data buses
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    typedef logic [STAT_W-1:0] status_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BAD_LEAD  = 2'd1;
    localparam status_t STATUS_BAD_CONT  = 2'd2;

    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_MATCH = 8'h80;

    typedef struct packed {
        status_t           status;
        logic [LEN_W-1:0]  seq_len;
        logic [CP_W-1:0]   code_point;
    } result_t;

endpackage

@@ src/utf8_byte_stream_decoder.sv @@
// ============================================================================
// utf8_byte_stream_decoder: one-byte-per-clock UTF-8 decoder (1 to 3 bytes) while the skid stage is free
// The result of the byte that completes a sequence (or triggers an error) is
// registered in the output register, or in the skid register if that is held.
// Throughput: one byte per cycle while the skid is empty (decode/update is
// combinational); a two-entry output stage absorbs one stalled result.
// Reset (rst_n low, asynchronous): decoder idle, no partial sequence, output
// and skid stages empty.
// ============================================================================
module utf8_byte_stream_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave side: [7:0] in_byte
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [u8dec_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // master side: [15:0] code_point, [17:16] seq_len, [23:18] zero
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [u8dec_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // master side: [1:0] status
    output logic [u8dec_pkg::STAT_W-1:0]        m_axis_tuser
);

    import u8dec_pkg::*;

    // Sequence state
    logic [1:0]        bytes_pending_reg, bytes_pending_next;
    logic [PART_W-1:0] partial_reg, partial_next;
    logic [LEN_W-1:0]  seq_total_reg, seq_total_next;

    // Output register and skid register
    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    logic        in_accept;
    logic        out_fire;
    logic        has_result;
    result_t     new_result;
    logic [7:0]  in_byte;
    logic        is_cont;

    assign in_byte   = s_axis_tdata[7:0];
    assign is_cont   = (in_byte & CONT_MASK) == CONT_MATCH;

    // Accept whenever the skid stage is free: the output register may still
    // hold a result the downstream has not taken yet.
    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;

    // ------------------------------------------------------------------
    // Byte decode and sequence state update
    // ------------------------------------------------------------------
    always_comb
    begin
        bytes_pending_next = bytes_pending_reg;
        partial_next       = partial_reg;
        seq_total_next     = seq_total_reg;
        has_result         = 1'b0;
        new_result         = '0;

        if (bytes_pending_reg == 2'd0)
        begin
            case (in_byte) inside
                [8'h00:8'h7F]:
                begin
                    // plain ASCII: emit right away
                    has_result            = 1'b1;
                    new_result.code_point = {8'h00, 1'b0, in_byte[6:0]};
                    new_result.seq_len    = 2'd1;
                    new_result.status     = STATUS_OK;
                end
                [8'hC0:8'hDF]:
                begin
                    // two-byte lead: keep the low five bits
                    partial_next       = {5'd0, in_byte[4:0]};
                    bytes_pending_next = 2'd1;
                    seq_total_next     = 2'd2;
                end
                [8'hE0:8'hEF]:
                begin
                    // three-byte lead: keep the low four bits
                    partial_next       = {6'd0, in_byte[3:0]};
                    bytes_pending_next = 2'd2;
                    seq_total_next     = 2'd3;
                end
                default:
                begin
                    // stray continuation or four-byte-and-up lead: drop
                    has_result        = 1'b1;
                    new_result.status = STATUS_BAD_LEAD;
                    partial_next      = '0;
                    seq_total_next    = '0;
                end
            endcase
        end
        else if (!is_cont)
        begin
            // broken sequence: drop it and the offending byte, back to idle
            has_result         = 1'b1;
            new_result.status  = STATUS_BAD_CONT;
            bytes_pending_next = 2'd0;
            partial_next       = '0;
            seq_total_next     = '0;
        end
        else if (bytes_pending_reg == 2'd1)
        begin
            // last continuation: sequence complete
            has_result            = 1'b1;
            new_result.code_point = {partial_reg, in_byte[5:0]};
            new_result.seq_len    = seq_total_reg;
            new_result.status     = STATUS_OK;
            bytes_pending_next    = 2'd0;
            partial_next          = '0;
            seq_total_next        = '0;
        end
        else
        begin
            // middle continuation: shift in six more bits
            partial_next       = {partial_reg[3:0], in_byte[5:0]};
            bytes_pending_next = bytes_pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_pending_reg <= 2'd0;
            partial_reg       <= '0;
            seq_total_reg     <= '0;
        end
        else if (in_accept)
        begin
            bytes_pending_reg <= bytes_pending_next;
            partial_reg       <= partial_next;
            seq_total_reg     <= seq_total_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // no intake here; advance the skid entry once the output drains
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_accept && has_result)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_accept && has_result)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= new_result;
            end
            else
            begin
                out_reg <= new_result;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-CP_W-LEN_W){1'b0}}, out_reg.seq_len,
                            out_reg.code_point};
    assign m_axis_tuser  = out_reg.status;

endmodule
